[rtl/core/bmla_pkg.sv]
// Package for the blocked matrix layout address generator.
// Holds widths, command and register codes, the block geometry type and
// small arithmetic helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bmla_pkg;

  localparam int DIM_W   = 13;
  localparam int ADDR_W  = 24;
  localparam int SPAN_W  = ADDR_W + 1;
  localparam int IDX_W   = 3;
  localparam int CMD_W   = 2;
  localparam int MAX_DIM = 4096;

  // Copy commands
  typedef enum logic [CMD_W-1:0] {
    CMD_A_BLOCK   = 2'd0,
    CMD_B_BLOCK   = 2'd1,
    CMD_C_ROWMAJ  = 2'd2,
    CMD_UNUSED    = 2'd3
  } cmd_t;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_ROW_COUNT    = 3'd0;
  localparam logic [IDX_W-1:0] REG_COL_COUNT    = 3'd1;
  localparam logic [IDX_W-1:0] REG_REDUCE_COUNT = 3'd2;
  localparam logic [IDX_W-1:0] REG_ROW_TILE     = 3'd3;
  localparam logic [IDX_W-1:0] REG_COL_TILE     = 3'd4;
  localparam logic [IDX_W-1:0] REG_REDUCE_TILE  = 3'd5;

  // Per-command block geometry, derived from the registers.
  // d1..d3 are the three divisors and total bounds the element index; the rest are multiplier operands.
  typedef struct packed {
    logic [SPAN_W-1:0] d1;
    logic [SPAN_W-1:0] d2;
    logic [SPAN_W-1:0] d3;
    logic [SPAN_W-1:0] total;
    logic [ADDR_W-1:0] x2;
    logic [ADDR_W-1:0] x3;
    logic [ADDR_W-1:0] p;
    logic [ADDR_W-1:0] r;
    logic [ADDR_W-1:0] y;
    logic [ADDR_W-1:0] f;
  } geom_t;

  // Low address bits of a product (addresses wrap)
  function automatic logic [ADDR_W-1:0] mul_lo(input logic [ADDR_W-1:0] a,
                                               input logic [ADDR_W-1:0] b);
    logic [2*ADDR_W-1:0] full;
    full = a * b;
    return full[ADDR_W-1:0];
  endfunction

  // Product of geometry values that never exceed 2^24
  function automatic logic [SPAN_W-1:0] mul_span(input logic [SPAN_W-1:0] a,
                                                 input logic [SPAN_W-1:0] b);
    logic [2*SPAN_W-1:0] full;
    full = a * b;
    return full[SPAN_W-1:0];
  endfunction

  function automatic logic [SPAN_W-1:0] ext_span(input logic [DIM_W-1:0] v);
    return {{(SPAN_W-DIM_W){1'b0}}, v};
  endfunction

endpackage

`default_nettype wire

[rtl/core/blocked_matrix_layout_address.sv]
// Top level of the blocked matrix layout address generator.
// Uses bmla_pkg for widths, codes, the geometry type and multiply helpers.
`timescale 1ns / 1ps
`default_nettype none

// One word in per clock while busy is low, one word out per clock. A word is taken when start
// is high and busy is low; its result shows on the result ports with done
// high for exactly one cycle, after one input register, 24 divider stages
// that resolve one quotient bit each and four multiply/add stages. Results
// cannot be held off. After reset and after every register write, busy
// stays high while the block geometry is rebuilt: a three-lane divider
// takes 13 steps for the block counts, then two multiply steps form
// divisors and copy sizes. Writes are meant for idle periods only. Out of
// range indexes and command 3 give in_range 0 and zero addresses.
module blocked_matrix_layout_address (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  command,
  input  wire logic [23:0]                 element_index,
  input  wire logic                        cfg_we,
  input  wire logic [bmla_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [bmla_pkg::DIM_W-1:0]  cfg_data,
  output logic                             done,
  output logic [bmla_pkg::ADDR_W-1:0]      source_address,
  output logic [bmla_pkg::ADDR_W-1:0]      dest_address,
  output logic                             in_range
);
  import bmla_pkg::*;

  localparam int LAT = ADDR_W + 5;

  typedef enum logic [2:0] {
    SEQ_LOAD, SEQ_DIV, SEQ_MUL1, SEQ_MUL2, SEQ_RUN
  } seq_state_t;

  // Configuration registers
  logic [DIM_W-1:0] row_count, col_count, reduce_count;
  logic [DIM_W-1:0] row_tile, col_tile, reduce_tile;
  logic [DIM_W-1:0] cfg_clamped;

  assign cfg_clamped = (cfg_data > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg_data;

  // Write registers, saturating at the largest dimension
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= DIM_W'(64);
      col_count    <= DIM_W'(64);
      reduce_count <= DIM_W'(64);
      row_tile     <= DIM_W'(16);
      col_tile     <= DIM_W'(16);
      reduce_tile  <= DIM_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_COUNT:    row_count    <= cfg_clamped;
        REG_COL_COUNT:    col_count    <= cfg_clamped;
        REG_REDUCE_COUNT: reduce_count <= cfg_clamped;
        REG_ROW_TILE:     row_tile     <= cfg_clamped;
        REG_COL_TILE:     col_tile     <= cfg_clamped;
        REG_REDUCE_TILE:  reduce_tile  <= cfg_clamped;
        default: ;
      endcase
    end
  end

  // Geometry sequencer state
  seq_state_t       seq_state;
  logic [3:0]       seq_cnt;
  logic [DIM_W-1:0] dq_r, dq_k, dq_c;     // dividend in, quotient out
  logic [DIM_W-1:0] dr_r, dr_k, dr_c;     // partial remainders
  logic [DIM_W-1:0] nk, nc;
  logic [SPAN_W-1:0] rows, kspan, cols, rk, kc, rc;
  geom_t geom_a, geom_b, geom_c;

  logic [DIM_W:0]   sh_r, sh_k, sh_c;
  logic             ge_r, ge_k, ge_c;
  logic [DIM_W-1:0] nr_v, nk_v, nc_v;

  // One restoring step per lane
  always_comb begin
    sh_r = {dr_r, dq_r[DIM_W-1]};
    sh_k = {dr_k, dq_k[DIM_W-1]};
    sh_c = {dr_c, dq_c[DIM_W-1]};
    ge_r = sh_r >= {1'b0, row_tile};
    ge_k = sh_k >= {1'b0, reduce_tile};
    ge_c = sh_c >= {1'b0, col_tile};
    // A zero tile means no whole block
    nr_v = (row_tile    == '0) ? '0 : dq_r;
    nk_v = (reduce_tile == '0) ? '0 : dq_k;
    nc_v = (col_tile    == '0) ? '0 : dq_c;
  end

  // Rebuild the geometry after reset or any write
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state <= SEQ_LOAD;
      seq_cnt   <= '0;
    end else if (cfg_we) begin
      seq_state <= SEQ_LOAD;
      seq_cnt   <= '0;
    end else begin
      unique case (seq_state)
        SEQ_LOAD: begin
          dq_r <= row_count;
          dq_k <= reduce_count;
          dq_c <= col_count;
          dr_r <= '0;
          dr_k <= '0;
          dr_c <= '0;
          seq_cnt   <= '0;
          seq_state <= SEQ_DIV;
        end
        SEQ_DIV: begin
          dr_r <= ge_r ? DIM_W'(sh_r - {1'b0, row_tile})    : sh_r[DIM_W-1:0];
          dr_k <= ge_k ? DIM_W'(sh_k - {1'b0, reduce_tile}) : sh_k[DIM_W-1:0];
          dr_c <= ge_c ? DIM_W'(sh_c - {1'b0, col_tile})    : sh_c[DIM_W-1:0];
          dq_r <= {dq_r[DIM_W-2:0], ge_r};
          dq_k <= {dq_k[DIM_W-2:0], ge_k};
          dq_c <= {dq_c[DIM_W-2:0], ge_c};
          seq_cnt <= seq_cnt + 4'd1;
          if (seq_cnt == 4'(DIM_W - 1)) begin
            seq_state <= SEQ_MUL1;
          end
        end
        SEQ_MUL1: begin
          nk    <= nk_v;
          nc    <= nc_v;
          rows  <= mul_span(ext_span(nr_v), ext_span(row_tile));
          kspan <= mul_span(ext_span(nk_v), ext_span(reduce_tile));
          cols  <= mul_span(ext_span(nc_v), ext_span(col_tile));
          rk    <= mul_span(ext_span(row_tile), ext_span(reduce_tile));
          kc    <= mul_span(ext_span(reduce_tile), ext_span(col_tile));
          rc    <= mul_span(ext_span(row_tile), ext_span(col_tile));
          seq_state <= SEQ_MUL2;
        end
        SEQ_MUL2: begin
          geom_a.d1    <= ext_span(row_tile);
          geom_a.d2    <= rk;
          geom_a.d3    <= mul_span(rk, ext_span(nk));
          geom_a.total <= mul_span(rows, kspan);
          geom_a.x2    <= ADDR_W'(reduce_tile);
          geom_a.x3    <= ADDR_W'(nk);
          geom_a.p     <= ADDR_W'(row_tile);
          geom_a.r     <= ADDR_W'(reduce_tile);
          geom_a.y     <= rk[ADDR_W-1:0];
          geom_a.f     <= ADDR_W'(reduce_count);
          geom_b.d1    <= ext_span(col_tile);
          geom_b.d2    <= kc;
          geom_b.d3    <= mul_span(kc, ext_span(nc));
          geom_b.total <= mul_span(kspan, cols);
          geom_b.x2    <= ADDR_W'(reduce_tile);
          geom_b.x3    <= ADDR_W'(nc);
          geom_b.p     <= ADDR_W'(reduce_tile);
          geom_b.r     <= ADDR_W'(col_tile);
          geom_b.y     <= kc[ADDR_W-1:0];
          geom_b.f     <= ADDR_W'(col_count);
          geom_c.d1    <= ext_span(col_tile);
          geom_c.d2    <= cols;
          geom_c.d3    <= mul_span(cols, ext_span(row_tile));
          geom_c.total <= mul_span(rows, cols);
          geom_c.x2    <= ADDR_W'(nc);
          geom_c.x3    <= ADDR_W'(row_tile);
          geom_c.p     <= ADDR_W'(nc);
          geom_c.r     <= ADDR_W'(col_tile);
          geom_c.y     <= ADDR_W'(col_count);
          geom_c.f     <= rc[ADDR_W-1:0];
          seq_state <= SEQ_RUN;
        end
        SEQ_RUN: ;
        default: seq_state <= SEQ_LOAD;
      endcase
    end
  end

  assign busy = (seq_state != SEQ_RUN);

  function automatic geom_t geom_sel(input logic [CMD_W-1:0] c, input geom_t ga,
                                     input geom_t gb, input geom_t gc);
    geom_t g;
    g = '0;
    case (cmd_t'(c))
      CMD_A_BLOCK:  g = ga;
      CMD_B_BLOCK:  g = gb;
      CMD_C_ROWMAJ: g = gc;
      default:      g = '0;
    endcase
    return g;
  endfunction

  // Divider pipeline: stage 0 is the input register, stages 1..ADDR_W
  // resolve one quotient bit each for the three divisors.
  logic                  dv_valid [ADDR_W+1];
  logic [CMD_W-1:0]      dv_cmd   [ADDR_W+1];
  logic [ADDR_W-1:0]     dv_e     [ADDR_W+1];
  logic                  dv_ok    [ADDR_W+1];
  logic [SPAN_W-1:0]     dv_rem   [ADDR_W+1][3];
  logic [ADDR_W-1:0]     dv_q     [ADDR_W+1][3];
  logic [SPAN_W-1:0]     nx_rem   [ADDR_W+1][3];
  logic [ADDR_W-1:0]     nx_q     [ADDR_W+1][3];
  logic                  ok1;

  always_comb begin
    geom_t             g;
    logic [SPAN_W-1:0] d [3];
    logic [SPAN_W:0]   sh;
    logic              ge;
    for (int s = 0; s <= ADDR_W; s++) begin
      for (int l = 0; l < 3; l++) begin
        nx_rem[s][l] = '0;
        nx_q[s][l]   = '0;
      end
    end
    for (int s = 1; s <= ADDR_W; s++) begin
      g = geom_sel(dv_cmd[s-1], geom_a, geom_b, geom_c);
      d[0] = g.d1;
      d[1] = g.d2;
      d[2] = g.d3;
      for (int l = 0; l < 3; l++) begin
        sh = {dv_rem[s-1][l], dv_e[s-1][ADDR_W-s]};
        ge = sh >= {1'b0, d[l]};
        nx_rem[s][l] = ge ? SPAN_W'(sh - {1'b0, d[l]}) : sh[SPAN_W-1:0];
        nx_q[s][l]   = {dv_q[s-1][l][ADDR_W-2:0], ge};
      end
    end
    g   = geom_sel(dv_cmd[0], geom_a, geom_b, geom_c);
    ok1 = {1'b0, dv_e[0]} < g.total;
  end

  // Advance the divider stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= ADDR_W; s++) begin
        dv_valid[s] <= 1'b0;
      end
    end else begin
      dv_valid[0] <= start && !busy;
      for (int s = 1; s <= ADDR_W; s++) begin
        dv_valid[s] <= dv_valid[s-1];
      end
    end
    dv_cmd[0] <= command;
    dv_e[0]   <= element_index;
    dv_ok[0]  <= 1'b0;
    for (int l = 0; l < 3; l++) begin
      dv_rem[0][l] <= '0;
      dv_q[0][l]   <= '0;
    end
    for (int s = 1; s <= ADDR_W; s++) begin
      dv_cmd[s] <= dv_cmd[s-1];
      dv_e[s]   <= dv_e[s-1];
      dv_ok[s]  <= (s == 1) ? ok1 : dv_ok[s-1];
      for (int l = 0; l < 3; l++) begin
        dv_rem[s][l] <= nx_rem[s][l];
        dv_q[s][l]   <= nx_q[s][l];
      end
    end
  end

  // Post stages: products, differences, multiply-adds, final address
  logic              p1_valid, p2_valid, p3_valid;
  logic [CMD_W-1:0]  p1_cmd, p2_cmd, p3_cmd;
  logic              p1_ok, p2_ok, p3_ok;
  logic [ADDR_W-1:0] p1_e, p1_q1, p1_q2, p1_q3, p1_m1, p1_m2, p1_m3, p1_m4;
  logic [ADDR_W-1:0] p2_q2, p2_q3, p2_u, p2_v, p2_w, p2_jc;
  logic [ADDR_W-1:0] p3_sa, p3_sb, p3_sc, p3_sd;
  geom_t g1, g3, g4;
  logic  is_a3, is_c3, is_c4;

  assign g1    = geom_sel(dv_cmd[ADDR_W], geom_a, geom_b, geom_c);
  assign g3    = geom_sel(p2_cmd, geom_a, geom_b, geom_c);
  assign g4    = geom_sel(p3_cmd, geom_a, geom_b, geom_c);
  assign is_a3 = (p2_cmd == CMD_A_BLOCK);
  assign is_c3 = (p2_cmd == CMD_C_ROWMAJ);
  assign is_c4 = (p3_cmd == CMD_C_ROWMAJ);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      p1_valid <= dv_valid[ADDR_W];
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      done     <= p3_valid;
    end
    // Quotient times divisor or block count
    p1_cmd <= dv_cmd[ADDR_W];
    p1_ok  <= dv_ok[ADDR_W];
    p1_e   <= dv_e[ADDR_W];
    p1_q1  <= dv_q[ADDR_W][0];
    p1_q2  <= dv_q[ADDR_W][1];
    p1_q3  <= dv_q[ADDR_W][2];
    p1_m1  <= mul_lo(dv_q[ADDR_W][0], g1.d1[ADDR_W-1:0]);
    p1_m2  <= mul_lo(dv_q[ADDR_W][1], g1.x2);
    p1_m3  <= mul_lo(dv_q[ADDR_W][2], g1.x3);
    p1_m4  <= mul_lo(dv_q[ADDR_W][1], g1.d2[ADDR_W-1:0]);
    // Remainders inside each level
    p2_cmd <= p1_cmd;
    p2_ok  <= p1_ok;
    p2_q2  <= p1_q2;
    p2_q3  <= p1_q3;
    p2_u   <= p1_e - p1_m1;
    p2_v   <= p1_q1 - p1_m2;
    p2_w   <= p1_q2 - p1_m3;
    p2_jc  <= p1_e - p1_m4;
    // Coordinates and partial destination
    p3_cmd <= p2_cmd;
    p3_ok  <= p2_ok;
    p3_sa  <= mul_lo(p2_q3, g3.p) + (is_a3 ? p2_u : p2_v);
    p3_sb  <= mul_lo(p2_w, g3.r) + (is_a3 ? p2_v : p2_u);
    p3_sc  <= mul_lo(p2_q2, g3.y) + (is_c3 ? p2_jc : '0);
    p3_sd  <= mul_lo(p2_v, g3.d1[ADDR_W-1:0]) + p2_u;
    // Final addresses, zero when out of range
    in_range       <= p3_ok;
    source_address <= p3_ok ? (mul_lo(p3_sa, g4.f) + p3_sb) : '0;
    dest_address   <= p3_ok ? (is_c4 ? p3_sc : (p3_sc + p3_sd)) : '0;
  end

  // Every result traces back to an accepted word
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without accepted word");

  assert property (@(posedge clk) disable iff (rst)
    done && in_range |-> $past(command, LAT) != CMD_UNUSED)
    else $error("unused command reported in range");

  assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> busy)
    else $error("geometry not rebuilt after write");

  assert property (@(posedge clk) disable iff (rst)
    !in_range |-> source_address == '0 && dest_address == '0 || !done)
    else $error("out of range word carries an address");

endmodule

`default_nettype wire
